[rtl/tmdf_pkg.sv]
package tmdf_pkg;

    // samples per axis in one poll, fixed by the median network
    localparam int SAMPLE_COUNT = 5;
    localparam int RANK_BITS    = 3;
    localparam logic [RANK_BITS-1:0] MEDIAN_RANK = RANK_BITS'(SAMPLE_COUNT / 2);

    // run counters
    localparam int RUN_BITS = 8;
    localparam logic [RUN_BITS-1:0] RUN_MAX = {RUN_BITS{1'b1}};

    // configuration port
    localparam int CFG_BITS     = 8;
    localparam int CFG_IDX_BITS = 1;
    localparam logic [CFG_BITS-1:0] PRESS_POLLS_RST   = 8'd2;
    localparam logic [CFG_BITS-1:0] RELEASE_POLLS_RST = 8'd4;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_PRESS_POLLS   = 1'b0,
        CFG_RELEASE_POLLS = 1'b1
    } t_cfg_idx;

    // per-poll commands from the debounce unit to the axis lanes
    typedef struct packed {
        logic load;   // first pressed poll: point takes the median
        logic step;   // pressed poll: IIR update
    } t_ctrl;

endpackage

[rtl/tmdf_lane.sv]
module tmdf_lane
    import tmdf_pkg::*;
#(
    parameter int SAMPLE_BITS = 12,
    parameter int IIR_ALPHA   = 4
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_s1_en,
    input  logic [SAMPLE_COUNT-1:0][SAMPLE_BITS-1:0] i_samples,
    input  t_ctrl                                   i_ctrl,
    output logic [SAMPLE_BITS-1:0]                  o_point
);

    // floor(d / IIR_ALPHA) for d = fresh - prev, done on the offset value
    // u = d + IIR_ALPHA * 2^SAMPLE_BITS by reciprocal multiply
    localparam int ALPHA_LOG = $clog2(IIR_ALPHA);
    localparam int U_BITS    = $clog2((IIR_ALPHA + 1) << SAMPLE_BITS);
    localparam int M_BITS    = U_BITS + 1;
    localparam int P_BITS    = U_BITS + M_BITS;
    localparam int Q_BITS    = SAMPLE_BITS + 1;
    localparam longint unsigned M_VAL =
        ((64'd1 << (U_BITS + ALPHA_LOG)) + IIR_ALPHA - 1) / IIR_ALPHA;
    localparam logic [M_BITS-1:0] M_K    = M_BITS'(M_VAL);
    localparam logic [U_BITS-1:0] OFS_K  = U_BITS'(IIR_ALPHA << SAMPLE_BITS);

    logic [RANK_BITS-1:0]   rank [SAMPLE_COUNT];
    logic [SAMPLE_BITS-1:0] med;
    logic [SAMPLE_BITS-1:0] r_med;
    logic [SAMPLE_BITS-1:0] r_smooth;
    logic [SAMPLE_BITS-1:0] n_smooth;
    logic [U_BITS-1:0]      u_val;
    logic [P_BITS-1:0]      prod;
    logic [Q_BITS-1:0]      quo;
    logic [Q_BITS-1:0]      sum;

    // median by rank: each sample counts the samples below it, ties by position
    always_comb begin
        for (int i = 0; i < SAMPLE_COUNT; i++) begin
            rank[i] = '0;
            for (int j = 0; j < SAMPLE_COUNT; j++) begin
                if (j != i) begin
                    if ((i_samples[j] < i_samples[i]) ||
                        ((i_samples[j] == i_samples[i]) && (j < i))) begin
                        rank[i] = rank[i] + RANK_BITS'(1);
                    end
                end
            end
        end
        med = '0;
        for (int i = 0; i < SAMPLE_COUNT; i++) begin
            if (rank[i] == MEDIAN_RANK) begin
                med = i_samples[i];
            end
        end
    end

    // stage 1: registered median
    always_ff @(posedge i_clk) begin
        if (i_s1_en) begin
            r_med <= med;
        end
    end

    // IIR: s + floor((m - s) / alpha); the offset 2^SAMPLE_BITS drops out
    // of the low bits
    always_comb begin
        u_val = U_BITS'(r_med) + OFS_K - U_BITS'(r_smooth);
        prod  = P_BITS'(u_val) * P_BITS'(M_K);
        quo   = prod[U_BITS + ALPHA_LOG +: Q_BITS];
        sum   = Q_BITS'(r_smooth) + quo;
        if (i_ctrl.load) begin
            n_smooth = r_med;
        end else if (i_ctrl.step) begin
            n_smooth = sum[SAMPLE_BITS-1:0];
        end else begin
            n_smooth = r_smooth;
        end
    end

    // smoothed point, doubles as the output word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_smooth <= '0;
        end else begin
            r_smooth <= n_smooth;
        end
    end

    assign o_point = r_smooth;

endmodule

[rtl/tmdf_debounce.sv]
module tmdf_debounce
    import tmdf_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0] i_cfg_idx,
    input  logic [CFG_BITS-1:0]     i_cfg_data,
    input  logic                    i_adv,
    input  logic                    i_touched,
    output t_ctrl                   o_ctrl,
    output logic                    o_pressed
);

    logic [CFG_BITS-1:0] r_press_polls;
    logic [CFG_BITS-1:0] r_release_polls;
    logic [RUN_BITS-1:0] r_touch_run;
    logic [RUN_BITS-1:0] r_release_run;
    logic                r_press;
    logic [RUN_BITS-1:0] touch_inc;
    logic [RUN_BITS-1:0] release_inc;
    logic [RUN_BITS-1:0] n_touch_run;
    logic [RUN_BITS-1:0] n_release_run;
    logic                n_press;

    // threshold registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_press_polls   <= PRESS_POLLS_RST;
            r_release_polls <= RELEASE_POLLS_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_PRESS_POLLS:   r_press_polls   <= i_cfg_data;
                CFG_RELEASE_POLLS: r_release_polls <= i_cfg_data;
            endcase
        end
    end

    // saturating run counters and press decision for the poll in stage 2
    always_comb begin
        touch_inc   = (r_touch_run == RUN_MAX) ? r_touch_run : r_touch_run + RUN_BITS'(1);
        release_inc = (r_release_run == RUN_MAX) ? r_release_run
                                                 : r_release_run + RUN_BITS'(1);
        n_touch_run   = r_touch_run;
        n_release_run = r_release_run;
        n_press       = r_press;
        o_ctrl        = '0;
        if (i_adv) begin
            if (i_touched) begin
                n_touch_run   = touch_inc;
                n_release_run = '0;
                if (r_press) begin
                    o_ctrl.step = 1'b1;
                end else if (touch_inc >= r_press_polls) begin
                    n_press     = 1'b1;
                    o_ctrl.load = 1'b1;
                end
            end else begin
                n_release_run = release_inc;
                n_touch_run   = '0;
                if (r_press && (release_inc >= r_release_polls)) begin
                    n_press = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_touch_run   <= '0;
            r_release_run <= '0;
            r_press       <= 1'b0;
        end else begin
            r_touch_run   <= n_touch_run;
            r_release_run <= n_release_run;
            r_press       <= n_press;
        end
    end

    assign o_pressed = r_press;

endmodule

[rtl/touch_median_debounce_filter.sv]
// Touch poll filter. Each input word is one poll: tuser carries the touched
// flag, tdata five X samples then five Y samples. Every poll yields exactly one
// output word with the debounced press state (tuser) and the smoothed X/Y
// point (tdata). Each axis runs in its own lane: a rank-based median of five
// is registered in stage 1, then a debounce unit with saturating touched and
// untouched run counters decides in stage 2 whether the point is loaded with
// the median (first pressed poll), stepped by s += floor((m - s)/IIR_ALPHA)
// (later pressed polls) or held. The stage-2 state registers are the output
// word. Latency is two register stages, the stage-1 median and touched flag
// and the stage-2 state registers. One poll is taken every cycle as long as
// the output side accepts one per cycle. The press_polls and release_polls
// thresholds are written through the cfg port; the user must do so only while
// no poll is in flight (not enforced by the block); a threshold of 0 acts as 1.
module touch_median_debounce_filter
    import tmdf_pkg::*;
#(
    parameter int IIR_ALPHA   = 4,
    parameter int SAMPLE_BITS = 12
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // configuration
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0] i_cfg_idx,
    input  logic [CFG_BITS-1:0]     i_cfg_data,
    // poll input
    input  logic                    i_s_tvalid,
    output logic                    o_s_tready,
    // x_sample_0..4, y_sample_0..4, zero pad
    input  logic [((2*SAMPLE_COUNT*SAMPLE_BITS+7)/8)*8-1:0] i_s_tdata,
    // touched
    input  logic                    i_s_tuser,
    // filtered output
    output logic                    o_m_tvalid,
    input  logic                    i_m_tready,
    // point_x, point_y, zero pad
    output logic [((2*SAMPLE_BITS+7)/8)*8-1:0] o_m_tdata,
    // pressed
    output logic                    o_m_tuser
);

    localparam int OUT_W = ((2*SAMPLE_BITS+7)/8)*8;

    logic [SAMPLE_COUNT-1:0][SAMPLE_BITS-1:0] x_samples;
    logic [SAMPLE_COUNT-1:0][SAMPLE_BITS-1:0] y_samples;
    logic                   r_s1_valid;
    logic                   r_s1_touched;
    logic                   r_out_valid;
    logic                   out_ready;
    logic                   s1_en;
    logic                   adv;
    t_ctrl                  ctrl;
    logic                   pressed;
    logic [SAMPLE_BITS-1:0] point_x;
    logic [SAMPLE_BITS-1:0] point_y;

    // unpack the input word
    always_comb begin
        for (int i = 0; i < SAMPLE_COUNT; i++) begin
            x_samples[i] = i_s_tdata[i*SAMPLE_BITS +: SAMPLE_BITS];
            y_samples[i] = i_s_tdata[(SAMPLE_COUNT+i)*SAMPLE_BITS +: SAMPLE_BITS];
        end
    end

    // pipeline handshake
    assign out_ready  = !r_out_valid || i_m_tready;
    assign adv        = r_s1_valid && out_ready;
    assign o_s_tready = !r_s1_valid || out_ready;
    assign s1_en      = i_s_tvalid && o_s_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s1_en) begin
                r_s1_valid <= 1'b1;
            end else if (adv) begin
                r_s1_valid <= 1'b0;
            end
            if (adv) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_en) begin
            r_s1_touched <= i_s_tuser;
        end
    end

    // axis lanes
    tmdf_lane #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .IIR_ALPHA   (IIR_ALPHA)
    ) u_lane_x (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s1_en   (s1_en),
        .i_samples (x_samples),
        .i_ctrl    (ctrl),
        .o_point   (point_x)
    );

    tmdf_lane #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .IIR_ALPHA   (IIR_ALPHA)
    ) u_lane_y (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s1_en   (s1_en),
        .i_samples (y_samples),
        .i_ctrl    (ctrl),
        .o_point   (point_y)
    );

    // press state and lane commands
    tmdf_debounce u_debounce (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_adv      (adv),
        .i_touched  (r_s1_touched),
        .o_ctrl     (ctrl),
        .o_pressed  (pressed)
    );

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = pressed;
    assign o_m_tdata  = OUT_W'({point_y, point_x});

`ifndef SYNTHESIS
    a_ctrl_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(ctrl.load && ctrl.step))
        else $error("load and step together");

    a_load_press: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctrl.load |=> pressed)
        else $error("point loaded without press");

    a_out_from_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_s1_valid))
        else $error("output word without stage 1 word");

    a_release_untouched: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(pressed) |-> $past(adv && !r_s1_touched))
        else $error("release on a touched poll");
`endif

endmodule

[tb/sv/tb_touch_median_debounce_filter.sv]
module tb_touch_median_debounce_filter;
    import tmdf_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int IIR_ALPHA   = 4;
    localparam int SAMPLE_BITS = 12;
    localparam int POLL_BITS   = ((2*SAMPLE_COUNT*SAMPLE_BITS+7)/8)*8;
    localparam int POINT_BITS  = ((2*SAMPLE_BITS+7)/8)*8;
    localparam int SAMPLE_TOP  = (1 << SAMPLE_BITS) - 1;
    localparam int SETTLE_CYCLES = 4;   // pipeline is two deep, plus margin

    typedef logic [SAMPLE_BITS-1:0] sample_t;
    typedef logic [SAMPLE_COUNT-1:0][SAMPLE_BITS-1:0] axis_t;

    typedef struct packed {
        logic    pressed;
        sample_t x;
        sample_t y;
    } point_word_t;

    logic                    i_clk;
    logic                    rst_n;
    logic                    cfg_we;
    t_cfg_idx                cfg_idx;
    logic [CFG_BITS-1:0]     cfg_data;
    logic                    poll_valid;
    logic                    poll_ready;
    logic [POLL_BITS-1:0]    poll_data;
    logic                    poll_touched;
    logic                    point_valid;
    logic                    point_ready;
    logic [POINT_BITS-1:0]   point_data;
    logic                    point_pressed;

    // filter state as predicted
    logic [RUN_BITS-1:0]     touch_run;
    logic [RUN_BITS-1:0]     release_run;
    logic                    is_pressed;
    sample_t                 smooth_x;
    sample_t                 smooth_y;
    logic [CFG_BITS-1:0]     press_need;
    logic [CFG_BITS-1:0]     release_need;

    point_word_t expected_points[$];
    int          error_count = 0;
    bit          steady = 1'b0;   // no idling on either side while set

    touch_median_debounce_filter #(
        .IIR_ALPHA   (IIR_ALPHA),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_s_tvalid (poll_valid),
        .o_s_tready (poll_ready),
        .i_s_tdata  (poll_data),
        .i_s_tuser  (poll_touched),
        .o_m_tvalid (point_valid),
        .i_m_tready (point_ready),
        .o_m_tdata  (point_data),
        .o_m_tuser  (point_pressed)
    );

    // 100 MHz clock
    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // idle length: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic sample_t median_of(axis_t a);
        sample_t v [SAMPLE_COUNT];
        sample_t t;
        for (int i = 0; i < SAMPLE_COUNT; i++) v[i] = a[i];
        for (int i = 0; i < SAMPLE_COUNT - 1; i++) begin
            for (int j = i + 1; j < SAMPLE_COUNT; j++) begin
                if (v[j] < v[i]) begin
                    t = v[i];
                    v[i] = v[j];
                    v[j] = t;
                end
            end
        end
        return v[SAMPLE_COUNT/2];
    endfunction

    // first-order low-pass, floor division
    function automatic sample_t smooth_step(sample_t prev, sample_t fresh);
        int acc;
        acc = int'(prev) * (IIR_ALPHA - 1) + int'(fresh);
        return sample_t'(acc / IIR_ALPHA);
    endfunction

    // advance the predicted filter by one accepted poll
    task automatic track_poll(input logic touched, input axis_t xs, input axis_t ys);
        sample_t mx;
        sample_t my;
        mx = median_of(xs);
        my = median_of(ys);
        if (touched) begin
            if (touch_run != RUN_MAX) touch_run = touch_run + 1'b1;
            release_run = '0;
            if (!is_pressed && touch_run >= press_need) begin
                is_pressed = 1'b1;
                smooth_x = mx;
                smooth_y = my;
            end
            if (is_pressed) begin
                smooth_x = smooth_step(smooth_x, mx);
                smooth_y = smooth_step(smooth_y, my);
            end
        end else begin
            if (release_run != RUN_MAX) release_run = release_run + 1'b1;
            touch_run = '0;
            if (is_pressed && release_run >= release_need) is_pressed = 1'b0;
        end
        expected_points.push_back('{pressed: is_pressed, x: smooth_x, y: smooth_y});
    endtask

    // one poll word through the input handshake
    task automatic send_poll(input logic touched, input axis_t xs, input axis_t ys);
        int gap;
        gap = steady ? 0 : pick_gap();
        if (gap > 0) begin
            poll_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        poll_valid   <= 1'b1;
        poll_touched <= touched;
        poll_data    <= POLL_BITS'({ys, xs});
        @(posedge i_clk);
        while (!poll_ready) @(posedge i_clk);
        track_poll(touched, xs, ys);
    endtask

    // stop sending and wait until every point word is back
    task automatic drain();
        poll_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_points.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // one register write, then write enable drops and the port idles before returning
    task automatic write_cfg(input t_cfg_idx idx, input logic [CFG_BITS-1:0] value);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= value;
        @(posedge i_clk);
        cfg_we   <= 1'b0;
        if (idx == CFG_PRESS_POLLS) press_need = value;
        else release_need = value;
        @(posedge i_clk);
    endtask

    function automatic axis_t axis5(int a, int b, int c, int d, int e);
        axis_t r;
        r[0] = sample_t'(a);
        r[1] = sample_t'(b);
        r[2] = sample_t'(c);
        r[3] = sample_t'(d);
        r[4] = sample_t'(e);
        return r;
    endfunction

    // mode 0: uniform, mode 1: noisy around center with an odd spike,
    // mode 2: rail values only
    function automatic axis_t make_axis(int mode, sample_t center);
        axis_t r;
        int v;
        for (int i = 0; i < SAMPLE_COUNT; i++) begin
            case (mode)
                0: v = $urandom_range(0, SAMPLE_TOP);
                1: begin
                    v = int'(center) + int'($urandom_range(0, 80)) - 40;
                    if (v < 0) v = 0;
                    if (v > SAMPLE_TOP) v = SAMPLE_TOP;
                    if ($urandom_range(0, 9) == 0) v = $urandom_range(0, SAMPLE_TOP);
                end
                default: v = $urandom_range(0, 1) ? SAMPLE_TOP : 0;
            endcase
            r[i] = sample_t'(v);
        end
        return r;
    endfunction

    task automatic send_untouched();
        send_poll(1'b0, make_axis(0, '0), make_axis(0, '0));
    endtask

    // default thresholds: press on second touched poll, release on fourth untouched
    task automatic test_defaults();
        send_untouched();
        send_poll(1'b1, axis5(4095, 4095, 4095, 4095, 4095), axis5(0, 0, 0, 0, 0));
        send_poll(1'b1, axis5(0, 4095, 0, 4095, 0), axis5(4095, 0, 4095, 0, 4095));
        send_poll(1'b1, axis5(4095, 4095, 4095, 4095, 4095), axis5(0, 0, 0, 0, 0));
        send_poll(1'b1, axis5(4000, 3000, 2000, 1000, 0), axis5(0, 1000, 2000, 3000, 4000));
        send_poll(1'b1, axis5(5, 7, 5, 7, 7), axis5(2048, 2047, 2048, 2049, 2047));
        send_poll(1'b1, axis5(1, 4095, 2, 4094, 3), axis5(2730, 1365, 0, 4095, 2730));
        repeat (3) send_untouched();
        send_poll(1'b1, axis5(100, 200, 300, 400, 500), axis5(900, 800, 700, 600, 500));
        repeat (4) send_untouched();
        // point held while released
        send_untouched();
        send_poll(1'b1, axis5(1234, 1234, 1234, 1234, 1234), axis5(321, 321, 321, 321, 321));
        send_untouched();
        send_poll(1'b1, axis5(3000, 10, 3000, 10, 3000), axis5(10, 3000, 10, 3000, 10));
        send_poll(1'b1, axis5(2222, 2222, 2222, 2222, 2222), axis5(3333, 3333, 3333, 3333, 3333));
        drain();
    endtask

    // zero threshold acts as one
    task automatic test_zero_thresholds();
        write_cfg(CFG_PRESS_POLLS, 8'd0);
        write_cfg(CFG_RELEASE_POLLS, 8'd0);
        send_poll(1'b1, make_axis(1, 12'd700), make_axis(1, 12'd3500));
        send_poll(1'b1, make_axis(1, 12'd900), make_axis(1, 12'd3000));
        send_untouched();
        send_poll(1'b1, make_axis(2, '0), make_axis(2, '0));
        send_untouched();
        drain();
        write_cfg(CFG_PRESS_POLLS, 8'd1);
        write_cfg(CFG_RELEASE_POLLS, 8'd1);
        send_poll(1'b1, make_axis(0, '0), make_axis(0, '0));
        send_poll(1'b1, make_axis(0, '0), make_axis(0, '0));
        send_untouched();
        send_untouched();
        drain();
    endtask

    // largest thresholds: counters must saturate rather than wrap
    task automatic test_long_runs();
        sample_t cx;
        sample_t cy;
        write_cfg(CFG_PRESS_POLLS, 8'd255);
        write_cfg(CFG_RELEASE_POLLS, 8'd255);
        cx = sample_t'($urandom_range(0, SAMPLE_TOP));
        cy = sample_t'($urandom_range(0, SAMPLE_TOP));
        repeat (258) send_poll(1'b1, make_axis(1, cx), make_axis(1, cy));
        repeat (258) send_untouched();
        repeat (3) send_poll(1'b1, make_axis(1, cx), make_axis(1, cy));
        drain();
    endtask

    // runs of touched and untouched polls sized around the thresholds
    task automatic run_traffic(input int count);
        int sent;
        int len;
        int thr;
        int mode;
        logic touched;
        sample_t cx;
        sample_t cy;
        sent = 0;
        touched = 1'($urandom_range(0, 1));
        while (sent < count) begin
            touched = ~touched;
            thr = touched ? int'(press_need) : int'(release_need);
            if (thr == 0) thr = 1;
            if ($urandom_range(0, 99) < 15) len = 1;
            else len = $urandom_range(1, thr + 6);
            if (len > count - sent) len = count - sent;
            mode = $urandom_range(0, 9);
            mode = (mode < 7) ? 1 : (mode < 9) ? 0 : 2;
            cx = sample_t'($urandom_range(0, SAMPLE_TOP));
            cy = sample_t'($urandom_range(0, SAMPLE_TOP));
            repeat (len) begin
                if (touched) send_poll(1'b1, make_axis(mode, cx), make_axis(mode, cy));
                else send_untouched();
                // finger drifts a little
                if ($urandom_range(0, 3) == 0) begin
                    cx = cx + sample_t'($urandom_range(0, 20)) - sample_t'(10);
                    cy = cy + sample_t'($urandom_range(0, 20)) - sample_t'(10);
                end
            end
            sent += len;
        end
    endtask

    task automatic test_random_phases();
        int r;
        for (int phase = 0; phase < 4; phase++) begin
            if (phase > 0) begin
                r = $urandom_range(0, 9);
                write_cfg(CFG_PRESS_POLLS, (r == 0) ? 8'd0 : CFG_BITS'($urandom_range(1, 8)));
                r = $urandom_range(0, 9);
                write_cfg(CFG_RELEASE_POLLS, (r == 0) ? 8'd0 : CFG_BITS'($urandom_range(1, 8)));
            end
            steady = (phase % 3 == 2);
            run_traffic(40);
            drain();
        end
        steady = 1'b0;
    endtask

    // output side: random backpressure
    initial begin
        int n;
        point_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            n = steady ? 0 : pick_gap();
            if (n > 0) begin
                point_ready <= 1'b0;
                repeat (n) @(posedge i_clk);
            end
            point_ready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
    end

    // compare every accepted point word with the oldest prediction
    always @(posedge i_clk) begin : check_point
        point_word_t want;
        if (rst_n && point_valid && point_ready) begin
            if (expected_points.size() == 0) begin
                $error("unexpected output word: pressed %0d x %0d y %0d",
                       point_pressed, point_data[SAMPLE_BITS-1:0],
                       point_data[2*SAMPLE_BITS-1:SAMPLE_BITS]);
                error_count++;
            end else begin
                want = expected_points.pop_front();
                if (point_pressed !== want.pressed) begin
                    $error("pressed: expected %0d, got %0d", want.pressed, point_pressed);
                    error_count++;
                end
                if (point_data[SAMPLE_BITS-1:0] !== want.x) begin
                    $error("point_x: expected %0d, got %0d", want.x,
                           point_data[SAMPLE_BITS-1:0]);
                    error_count++;
                end
                if (point_data[2*SAMPLE_BITS-1:SAMPLE_BITS] !== want.y) begin
                    $error("point_y: expected %0d, got %0d", want.y,
                           point_data[2*SAMPLE_BITS-1:SAMPLE_BITS]);
                    error_count++;
                end
            end
        end
    end

    // watchdog
    initial begin
        #10ms;
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        rst_n        <= 1'b0;
        cfg_we       <= 1'b0;
        cfg_idx      <= CFG_PRESS_POLLS;
        cfg_data     <= '0;
        poll_valid   <= 1'b0;
        poll_touched <= 1'b0;
        poll_data    <= '0;
        touch_run    = '0;
        release_run  = '0;
        is_pressed   = 1'b0;
        smooth_x     = '0;
        smooth_y     = '0;
        press_need   = PRESS_POLLS_RST;
        release_need = RELEASE_POLLS_RST;
        repeat (12) @(posedge i_clk);
        rst_n <= 1'b1;
        @(posedge i_clk);

        test_defaults();
        test_zero_thresholds();
        test_long_runs();
        test_random_phases();

        drain();
        if (error_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
